>>> rtl/assert_macros.svh
// Assertion helpers for the envelope block.
// Both sample on aclk and stay quiet while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ADSR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ADSR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/adsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package adsr_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS  = 16;
    localparam int AMP_BITS     = 16;
    localparam int QUO_BITS     = AMP_BITS;
    localparam int Q_SHIFT      = 15;
    localparam int LEN_BITS_DEF = 20;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_AMP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUS_AMP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN   = 3'd5;

    localparam logic [AMP_BITS-1:0] MAX_AMP_RST = 16'd32768;
    localparam logic [AMP_BITS-1:0] SUS_AMP_RST = 16'd16384;

    // Input beat
    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] sample_in;
    } adsr_in_t;

    // Result beat
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [AMP_BITS-1:0]           level;
        logic                          active;
    } adsr_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture_in;
        logic latch_trig;
        logic align_total;
        logic set_sus_end;
        logic setup_level;
        logic mul;
        logic div_load;
        logic div_step;
        logic make_level;
        logic scale;
        logic emit_env;
        logic emit_pass;
    } adsr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_trigger;
        logic pass_thru;
        logic out_free;
    } adsr_stat_t;

endpackage
`default_nettype wire

>>> rtl/adsr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module adsr_cfg
    import adsr_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic [AMP_BITS-1:0]        max_amp,
    output logic [AMP_BITS-1:0]        sus_amp,
    output logic [LEN_BITS-1:0]        att_len,
    output logic [LEN_BITS-1:0]        dec_len,
    output logic [LEN_BITS-1:0]        rel_len,
    output logic                       align
);

    logic [AMP_BITS-1:0] max_amp_reg;
    logic [AMP_BITS-1:0] sus_amp_reg;
    logic [LEN_BITS-1:0] att_len_reg;
    logic [LEN_BITS-1:0] dec_len_reg;
    logic [LEN_BITS-1:0] rel_len_reg;
    logic                align_reg;

    // Always take register writes
    assign cfg_ready = 1'b1;

    // Write the addressed register, drop unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_amp_reg <= MAX_AMP_RST;
            sus_amp_reg <= SUS_AMP_RST;
            att_len_reg <= '0;
            dec_len_reg <= '0;
            rel_len_reg <= '0;
            align_reg   <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_AMP: max_amp_reg <= cfg_data[AMP_BITS-1:0];
                REG_SUS_AMP: sus_amp_reg <= cfg_data[AMP_BITS-1:0];
                REG_ATTACK:  att_len_reg <= cfg_data[LEN_BITS-1:0];
                REG_DECAY:   dec_len_reg <= cfg_data[LEN_BITS-1:0];
                REG_RELEASE: rel_len_reg <= cfg_data[LEN_BITS-1:0];
                REG_ALIGN:   align_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign max_amp = max_amp_reg;
    assign sus_amp = sus_amp_reg;
    assign att_len = att_len_reg;
    assign dec_len = dec_len_reg;
    assign rel_len = rel_len_reg;
    assign align   = align_reg;

endmodule
`default_nettype wire

>>> rtl/adsr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module adsr_dp
    import adsr_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire adsr_cmd_t           cmd,
    output adsr_stat_t               stat,
    input  wire adsr_in_t            s_data,
    input  wire logic [AMP_BITS-1:0] max_amp,
    input  wire logic [AMP_BITS-1:0] sus_amp,
    input  wire logic [LEN_BITS-1:0] att_len,
    input  wire logic [LEN_BITS-1:0] dec_len,
    input  wire logic [LEN_BITS-1:0] rel_len,
    input  wire logic                align,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output adsr_out_t                m_data
);

    localparam int POS_W       = LEN_BITS + 3;
    localparam int NUM_W       = AMP_BITS + LEN_BITS;
    localparam int SMEAR_STEPS = $clog2(POS_W);
    localparam int SCL_W       = SAMPLE_BITS + AMP_BITS + 1;
    localparam int SHF_W       = SCL_W - Q_SHIFT;

    // Captured beat and envelope state
    adsr_in_t            in_reg;
    logic [AMP_BITS-1:0] lat_max_reg, lat_sus_reg;
    logic [LEN_BITS-1:0] lat_att_reg, lat_dec_reg, lat_rel_reg;
    logic                align_lat_reg;
    logic [LEN_BITS:0]   ad_end_reg;
    logic [POS_W-1:0]    total_reg, total_next;
    logic [POS_W-1:0]    sus_end_reg;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                running_reg, running_next;

    // Level operands
    logic [AMP_BITS-1:0] op_a_reg, op_a_next;
    logic [LEN_BITS-1:0] op_b_reg, op_b_next;
    logic [LEN_BITS-1:0] div_reg, div_next;
    logic [AMP_BITS-1:0] base_reg, base_next;
    logic                sub_reg, sub_next;
    logic                nodiv_reg, nodiv_next;

    // Multiplier, divider and scaling
    logic [NUM_W-1:0]        prod_reg;
    logic [LEN_BITS-1:0]     rem_reg;
    logic [QUO_BITS-1:0]     quo_reg;
    logic [AMP_BITS-1:0]     level_reg, level_next;
    logic signed [SCL_W-1:0] scale_reg;
    adsr_out_t               out_reg, out_next;
    logic                    m_valid_reg, m_valid_next;

    logic [POS_W-1:0]    smear;
    logic [POS_W-1:0]    total_pow2;
    logic [LEN_BITS:0]   trial;
    logic [LEN_BITS:0]   trial_diff;
    logic                trial_ge;
    logic [QUO_BITS-1:0] quo_eff;
    logic [AMP_BITS:0]   level_sum;
    logic [SHF_W-1:0]    shifted;
    logic                fits;

    // Round the total up to a power of two by smearing the top bit down
    always_comb begin
        smear = total_reg - POS_W'(1);
        for (int i = 0; i < SMEAR_STEPS; i++) begin
            smear = smear | (smear >> (1 << i));
        end
        total_pow2 = smear + POS_W'(1);
    end

    // Pick the ramp segment and its operands
    always_comb begin
        op_a_next  = '0;
        op_b_next  = '0;
        div_next   = '0;
        base_next  = lat_sus_reg;
        sub_next   = 1'b0;
        nodiv_next = 1'b1;
        if (pos_reg <= POS_W'(lat_att_reg)) begin
            op_a_next  = lat_max_reg;
            op_b_next  = pos_reg[LEN_BITS-1:0];
            div_next   = lat_att_reg;
            base_next  = '0;
            nodiv_next = (lat_att_reg == '0);
        end else if (pos_reg <= POS_W'(ad_end_reg)) begin
            op_b_next  = pos_reg[LEN_BITS-1:0] - lat_att_reg;
            div_next   = lat_dec_reg;
            base_next  = lat_max_reg;
            nodiv_next = 1'b0;
            if (lat_sus_reg >= lat_max_reg) begin
                op_a_next = lat_sus_reg - lat_max_reg;
                sub_next  = 1'b0;
            end else begin
                op_a_next = lat_max_reg - lat_sus_reg;
                sub_next  = 1'b1;
            end
        end else if (pos_reg > sus_end_reg) begin
            op_a_next  = lat_sus_reg;
            op_b_next  = LEN_BITS'(pos_reg - sus_end_reg);
            div_next   = lat_rel_reg;
            sub_next   = 1'b1;
            nodiv_next = (lat_rel_reg == '0);
        end
    end

    // One restoring division step: one quotient bit per cycle
    assign trial      = {rem_reg, quo_reg[QUO_BITS-1]};
    assign trial_ge   = (trial >= {1'b0, div_reg});
    assign trial_diff = trial - {1'b0, div_reg};

    // Apply the ramp to its starting level
    always_comb begin
        quo_eff   = nodiv_reg ? '0 : quo_reg;
        level_sum = {1'b0, base_reg} + {1'b0, quo_eff};
        if (sub_reg) begin
            level_next = (base_reg >= quo_eff) ? (base_reg - quo_eff) : '0;
        end else begin
            level_next = level_sum[AMP_BITS-1:0];
        end
    end

    // Drop the Q1.15 fraction and saturate to the sample range
    assign shifted = scale_reg[SCL_W-1:Q_SHIFT];
    assign fits    = (shifted[SHF_W-1:SAMPLE_BITS-1] == '0)
                  || (shifted[SHF_W-1:SAMPLE_BITS-1] == '1);

    // Build the result beat
    always_comb begin
        out_next = out_reg;
        if (cmd.emit_pass) begin
            out_next.sample_out = in_reg.sample_in;
            out_next.level      = '0;
            out_next.active     = 1'b0;
        end else if (cmd.emit_env) begin
            if (fits) begin
                out_next.sample_out = shifted[SAMPLE_BITS-1:0];
            end else if (shifted[SHF_W-1]) begin
                out_next.sample_out = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end else begin
                out_next.sample_out = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            end
            out_next.level  = level_reg;
            out_next.active = 1'b1;
        end
    end

    // Envelope control state
    always_comb begin
        total_next   = total_reg;
        pos_next     = pos_reg;
        running_next = running_reg;
        m_valid_next = m_valid_reg;
        if (cmd.latch_trig) begin
            total_next   = POS_W'(att_len) + POS_W'(dec_len) + POS_W'(rel_len);
            pos_next     = '0;
            running_next = 1'b1;
        end
        if (cmd.align_total && align_lat_reg) begin
            total_next = total_pow2;
        end
        if (cmd.emit_pass) begin
            running_next = 1'b0;
        end
        if (cmd.emit_env) begin
            pos_next = pos_reg + POS_W'(1);
        end
        if (cmd.emit_env || cmd.emit_pass) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= '0;
            pos_reg     <= '0;
            running_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            total_reg   <= total_next;
            pos_reg     <= pos_next;
            running_reg <= running_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture_in) begin
            in_reg <= s_data;
        end
        if (cmd.latch_trig) begin
            lat_max_reg   <= max_amp;
            lat_sus_reg   <= sus_amp;
            lat_att_reg   <= att_len;
            lat_dec_reg   <= dec_len;
            lat_rel_reg   <= rel_len;
            align_lat_reg <= align;
            ad_end_reg    <= {1'b0, att_len} + {1'b0, dec_len};
        end
        if (cmd.set_sus_end) begin
            sus_end_reg <= total_reg - POS_W'(lat_rel_reg);
        end
        if (cmd.setup_level) begin
            op_a_reg  <= op_a_next;
            op_b_reg  <= op_b_next;
            div_reg   <= div_next;
            base_reg  <= base_next;
            sub_reg   <= sub_next;
            nodiv_reg <= nodiv_next;
        end
        if (cmd.mul) begin
            prod_reg <= op_a_reg * op_b_reg;
        end
        if (cmd.div_load) begin
            rem_reg <= prod_reg[NUM_W-1:QUO_BITS];
            quo_reg <= prod_reg[QUO_BITS-1:0];
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
            quo_reg <= {quo_reg[QUO_BITS-2:0], trial_ge};
        end
        if (cmd.make_level) begin
            level_reg <= level_next;
        end
        if (cmd.scale) begin
            scale_reg <= in_reg.sample_in * $signed({1'b0, level_reg});
        end
        out_reg <= out_next;
    end

    assign stat.is_trigger = in_reg.action;
    assign stat.pass_thru  = !running_reg || (pos_reg == total_reg);
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

>>> rtl/adsr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module adsr_ctrl
    import adsr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire adsr_stat_t stat,
    output adsr_cmd_t       cmd
);

    localparam int ST_W  = 4;
    localparam int CNT_W = $clog2(QUO_BITS);

    localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] ST_DECIDE = 4'd1;
    localparam logic [ST_W-1:0] ST_ALIGN  = 4'd2;
    localparam logic [ST_W-1:0] ST_SUSEND = 4'd3;
    localparam logic [ST_W-1:0] ST_PASS   = 4'd4;
    localparam logic [ST_W-1:0] ST_MUL    = 4'd5;
    localparam logic [ST_W-1:0] ST_DLOAD  = 4'd6;
    localparam logic [ST_W-1:0] ST_DIV    = 4'd7;
    localparam logic [ST_W-1:0] ST_LEVEL  = 4'd8;
    localparam logic [ST_W-1:0] ST_SCALE  = 4'd9;
    localparam logic [ST_W-1:0] ST_EMIT   = 4'd10;

    logic [ST_W-1:0]  state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Sequence one beat through the datapath
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture_in = 1'b1;
                    state_next     = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.is_trigger) begin
                    cmd.latch_trig = 1'b1;
                    state_next     = ST_ALIGN;
                end else if (stat.pass_thru) begin
                    state_next = ST_PASS;
                end else begin
                    cmd.setup_level = 1'b1;
                    state_next      = ST_MUL;
                end
            end
            ST_ALIGN: begin
                cmd.align_total = 1'b1;
                state_next      = ST_SUSEND;
            end
            ST_SUSEND: begin
                cmd.set_sus_end = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_PASS: begin
                if (stat.out_free) begin
                    cmd.emit_pass = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DLOAD;
            end
            ST_DLOAD: begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(QUO_BITS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_LEVEL;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_LEVEL: begin
                cmd.make_level = 1'b1;
                state_next     = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_env = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/linear_adsr_envelope_top.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Linear ADSR envelope. A beat with action set restarts the envelope from the
// amplitude and length registers as they stand then; a beat with action clear
// shapes one signed sample by the current Q1.15 level and returns one result
// beat (triggers return none). The block works on one input beat at a time
// but takes the next while a result still waits on m_ready. An enveloped
// sample goes through the multiply, the 16-step restoring divider that forms
// each ramp level, the level and scale states before the next is accepted; a
// pass-through sample and a trigger skip these. Register writes are always
// taken and act at the next trigger.
module linear_adsr_envelope_top
    import adsr_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire adsr_in_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output adsr_out_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    adsr_cmd_t           cmd;
    adsr_stat_t          stat;
    logic [AMP_BITS-1:0] max_amp, sus_amp;
    logic [LEN_BITS-1:0] att_len, dec_len, rel_len;
    logic                align;

    adsr_cfg #(
        .LEN_BITS(LEN_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .max_amp   (max_amp),
        .sus_amp   (sus_amp),
        .att_len   (att_len),
        .dec_len   (dec_len),
        .rel_len   (rel_len),
        .align     (align)
    );

    adsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    adsr_dp #(
        .LEN_BITS(LEN_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_data),
        .max_amp (max_amp),
        .sus_amp (sus_amp),
        .att_len (att_len),
        .dec_len (dec_len),
        .rel_len (rel_len),
        .align   (align),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Never overwrite a result beat that is still pending
    `ADSR_ASSERT_IMP(a_emit_free, cmd.emit_env || cmd.emit_pass, !m_valid || m_ready, "result written over a pending beat")
    // Hold off new beats while one is in flight
    `ADSR_ASSERT_NXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "second beat accepted while busy")
    // A result appears only after the controller emits one
    `ADSR_ASSERT_IMP(a_valid_from_emit, $rose(m_valid), $past(cmd.emit_env || cmd.emit_pass), "result valid without an emit")
    // Pass-through results carry no level
    `ADSR_ASSERT_IMP(a_pass_level, m_valid && !m_data.active, m_data.level == '0, "inactive result with nonzero level")

endmodule
`default_nettype wire
